/* hdl/tsc_pkg.sv */
// ----------------------------------------------------------------------------
// Threshold stream compaction package
// Compare relation codes, register indexes and the float compare helper.
// ----------------------------------------------------------------------------
package tsc_pkg;

   localparam int unsigned FloatWidth = 32;
   localparam int unsigned ModeWidth  = 3;
   localparam int unsigned CsrIdxWidth = 1;

   typedef enum logic [ModeWidth-1:0] {
      CMP_GT = 3'd0,
      CMP_LT = 3'd1,
      CMP_EQ = 3'd2,
      CMP_GE = 3'd3,
      CMP_LE = 3'd4
   } cmp_mode_type;

   localparam logic [CsrIdxWidth-1:0] CSR_COMPARE_MODE   = 1'b0;
   localparam logic [CsrIdxWidth-1:0] CSR_THRESHOLD_BITS = 1'b1;

   function automatic logic is_nan(input logic [FloatWidth-1:0] b);
      is_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
   endfunction

   // Ordered compare of two single-precision patterns; both zeros are equal.
   function automatic logic float_passes(input logic [FloatWidth-1:0] v,
                                         input logic [FloatWidth-1:0] t,
                                         input logic [ModeWidth-1:0]  mode);
      logic signed [FloatWidth:0] a;
      logic signed [FloatWidth:0] c;
      logic gt;
      logic eq;
      a = v[31] ? -$signed({2'b00, v[30:0]}) : $signed({2'b00, v[30:0]});
      c = t[31] ? -$signed({2'b00, t[30:0]}) : $signed({2'b00, t[30:0]});
      gt = a > c;
      eq = a == c;
      if (is_nan(v) || is_nan(t)) begin
         float_passes = 1'b0;
      end else begin
         unique case (mode)
            CMP_GT:  float_passes = gt;
            CMP_LT:  float_passes = !gt && !eq;
            CMP_EQ:  float_passes = eq;
            CMP_GE:  float_passes = gt || eq;
            CMP_LE:  float_passes = !gt;
            default: float_passes = 1'b0;
         endcase
      end
   endfunction

endpackage

/* hdl/tsc_compact.sv */
// ----------------------------------------------------------------------------
// Lane compare and compaction
// Compares each valid lane with the threshold and packs passing lanes low.
// ----------------------------------------------------------------------------
module tsc_compact import tsc_pkg::*; #(
   parameter int unsigned LANES = 8
) (
   input  logic [LANES*FloatWidth-1:0]  lanes,
   input  logic [3:0]                   lanes_valid,
   input  logic [ModeWidth-1:0]         mode,
   input  logic [FloatWidth-1:0]        threshold,
   output logic [LANES*FloatWidth-1:0]  kept,
   output logic [$clog2(LANES+1)-1:0]   kept_count
);
   localparam int unsigned CW = $clog2(LANES+1);

   logic [LANES-1:0] pass;
   logic [CW-1:0]    pos [LANES+1];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         pass[i] = (i < int'(lanes_valid)) &&
                   float_passes(lanes[i*FloatWidth +: FloatWidth], threshold, mode);
      end
      pos[0] = '0;
      for (int i = 0; i < LANES; i++) begin
         pos[i+1] = pos[i] + CW'(pass[i]);
      end
      // Output lane j takes the input lane whose prefix count equals j.
      kept = '0;
      for (int j = 0; j < LANES; j++) begin
         for (int i = 0; i < LANES; i++) begin
            if (pass[i] && (pos[i] == CW'(j))) begin
               kept[j*FloatWidth +: FloatWidth] = lanes[i*FloatWidth +: FloatWidth];
            end
         end
      end
      kept_count = pos[LANES];
   end
endmodule

/* hdl/threshold_stream_compaction.sv */
// ----------------------------------------------------------------------------
// Threshold stream compaction
// Filters eight float lanes against a threshold and packs the survivors.
// ----------------------------------------------------------------------------
// Channel  Direction  Content
// req      in         lanes, lanes_valid (tdata), last_item (tlast)
// rsp      out        kept lanes, kept_count, stream_total (tdata), end (tlast)
// csr      in         register index and write data
//
// One beat is taken every cycle while req_tready is high; a result appears the cycle after its beat.
// The single result register sets the latency; req_tready follows
// rsp_tready or an empty result register, so stalls pass straight back.
// Reset clears the CSR registers, the running total and the result valid flag; result data is not reset.
module threshold_stream_compaction import tsc_pkg::*; #(
   parameter int unsigned LANES       = 8,
   parameter int unsigned TOTAL_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // lane_0 .. lane_(LANES-1), lanes_valid[3:0], zero pad to bytes
   input  logic [((LANES*32+4+7)/8)*8-1:0] req_tdata,
   input  logic                         req_tlast,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // kept_0 .. kept_(LANES-1), kept_count, stream_total, zero pad to bytes
   output logic [((LANES*32+$clog2(LANES+1)+TOTAL_WIDTH+7)/8)*8-1:0] rsp_tdata,
   output logic                         rsp_tlast,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CsrIdxWidth-1:0]       csr_index,
   input  logic [31:0]                  csr_data
);
   localparam int unsigned LW = LANES*FloatWidth;
   localparam int unsigned CW = $clog2(LANES+1);
   localparam int unsigned RW = ((LW+CW+TOTAL_WIDTH+7)/8)*8;

   logic [ModeWidth-1:0]   mode_ff;
   logic [FloatWidth-1:0]  thr_ff;
   logic [TOTAL_WIDTH-1:0] total_ff, total_in, sum;
   logic [TOTAL_WIDTH:0]   wide_sum;
   logic                   valid_ff;
   logic [LW-1:0]          kept_ff, kept_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [TOTAL_WIDTH-1:0] rtot_ff;
   logic                   last_ff;
   logic [3:0]             nvalid;
   logic                   take;

   assign csr_ready  = 1'b1;
   assign req_tready = !valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;
   assign nvalid     = req_tdata[LW +: 4];

   tsc_compact #(.LANES(LANES)) u_compact (
      .lanes      (req_tdata[LW-1:0]),
      .lanes_valid(nvalid),
      .mode       (mode_ff),
      .threshold  (thr_ff),
      .kept       (kept_in),
      .kept_count (count_in)
   );

   assign wide_sum = {1'b0, total_ff} + (TOTAL_WIDTH+1)'(count_in);
   assign sum      = wide_sum[TOTAL_WIDTH] ? '1 : wide_sum[TOTAL_WIDTH-1:0];
   assign total_in = req_tlast ? '0 : sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= '0;
         thr_ff   <= '0;
         total_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_COMPARE_MODE:   mode_ff <= csr_data[ModeWidth-1:0];
               CSR_THRESHOLD_BITS: thr_ff  <= csr_data;
               default: ;
            endcase
         end
         if (take) begin
            total_ff <= total_in;
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kept_ff  <= kept_in;
         count_ff <= count_in;
         rtot_ff  <= sum;
         last_ff  <= req_tlast;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = RW'({rtot_ff, count_ff, kept_ff});
endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// Threshold stream compaction testbench
// Streams float lane beats through the filter under many relation and
// threshold settings. Every result beat is checked against a local predictor.
// ----------------------------------------------------------------------------
module tb_top;
   import tsc_pkg::*;

   localparam int NumLanes = 8;
   localparam int ReqBits  = 264;
   localparam int RspBits  = 296;
   localparam int CycleLimit = 400000;

   typedef struct {
      logic [NumLanes-1:0][31:0] lane;
      logic [3:0]                lanes_valid;
      logic                      last;
   } lane_beat_type;

   typedef struct {
      logic [NumLanes-1:0][31:0] kept;
      logic [3:0]                kept_count;
      logic [31:0]               total;
      logic                      eos;
   } kept_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [ReqBits-1:0] req_tdata = '0;
   logic               req_tlast = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RspBits-1:0] rsp_tdata;
   logic               rsp_tlast;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [31:0]        csr_data = '0;

   threshold_stream_compaction dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lane_beat_type pending_beats[$];
   kept_beat_type expected_kept[$];
   lane_beat_type on_wire;
   logic [2:0]  relation = 3'd0;
   logic [31:0] threshold = '0;
   logic [31:0] running_total = '0;
   logic        steady = 1'b0;
   logic        hold_request = 1'b0;
   int          hold_left = 0;
   int          beats_queued = 0;
   int          results_seen = 0;
   int          error_count = 0;
   int          cycle_count = 0;

   function automatic logic float_is_nan(logic [31:0] b);
      return b[30:23] == 8'hFF && b[22:0] != 0;
   endfunction

   // Sign-magnitude to a signed key; both zeros land on zero.
   function automatic logic signed [32:0] order_key(logic [31:0] b);
      logic signed [32:0] mag;
      mag = {2'b00, b[30:0]};
      return b[31] ? -mag : mag;
   endfunction

   function automatic logic lane_passes(logic [31:0] v);
      logic signed [32:0] a;
      logic signed [32:0] c;
      a = order_key(v);
      c = order_key(threshold);
      if (float_is_nan(v) || float_is_nan(threshold)) return 1'b0;
      case (relation)
         CMP_GT:  return a > c;
         CMP_LT:  return a < c;
         CMP_EQ:  return a == c;
         CMP_GE:  return a >= c;
         CMP_LE:  return a <= c;
         default: return 1'b0;
      endcase
   endfunction

   function automatic kept_beat_type compact_lanes(lane_beat_type b);
      kept_beat_type r;
      int n;
      int limit;
      logic [32:0] sum;
      r.kept = '0;
      n = 0;
      limit = b.lanes_valid > NumLanes ? NumLanes : b.lanes_valid;
      for (int i = 0; i < limit; i++) begin
         if (lane_passes(b.lane[i])) begin
            r.kept[n] = b.lane[i];
            n++;
         end
      end
      sum = {1'b0, running_total} + n;
      running_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      r.kept_count = n[3:0];
      r.total = running_total;
      r.eos = b.last;
      if (b.last) running_total = '0;
      return r;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at result %0d: %s got %h expected %h", results_seen, what, got,
               want);
      error_count++;
   endtask

   // Sender side.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) expected_kept.push_back(compact_lanes(on_wire));
         if (!req_tvalid || req_tready) begin
            if (pending_beats.size() > 0 && (steady || $urandom_range(99) >= 34)) begin
               on_wire = pending_beats.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {4'h0, on_wire.lanes_valid, on_wire.lane};
               req_tlast <= on_wire.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, requested once by the stimulus.
   always @(posedge clock) begin
      if (reset) hold_left <= 0;
      else if (hold_request && hold_left == 0) hold_left <= 400;
      else if (hold_left > 0) hold_left <= hold_left - 1;
   end

   // Receiver side.
   always @(posedge clock) begin
      kept_beat_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_kept.size() == 0) begin
               report("unexpected beat", rsp_tdata[291:260], '0);
            end else begin
               e = expected_kept.pop_front();
               for (int i = 0; i < NumLanes; i++)
                  if (rsp_tdata[32*i +: 32] !== e.kept[i])
                     report($sformatf("kept_%0d", i), rsp_tdata[32*i +: 32], e.kept[i]);
               if (rsp_tdata[259:256] !== e.kept_count)
                  report("kept_count", rsp_tdata[259:256], e.kept_count);
               if (rsp_tdata[291:260] !== e.total)
                  report("stream_total", rsp_tdata[291:260], e.total);
               if (rsp_tlast !== e.eos) report("end_of_stream", rsp_tlast, e.eos);
            end
            results_seen++;
         end
         rsp_tready <= hold_left == 0 && (steady || $urandom_range(99) >= 34);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("threshold_stream_compaction regression: fail");
         $finish;
      end
   end

   task automatic write_csr(logic [CsrIdxWidth-1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_COMPARE_MODE) relation = value[2:0];
      else threshold = value;
   endtask

   task automatic wait_drained();
      while (results_seen != beats_queued) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_lane();
      case ($urandom_range(9))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return $urandom_range(1) ? 32'h7F80_0000 : 32'hFF80_0000;
         3: return {$urandom_range(1) ? 1'b1 : 1'b0, 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
         4: return threshold;
         5: return threshold ^ 32'h1;
         6: return threshold ^ 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_beat(logic [NumLanes-1:0][31:0] lanes, logic [3:0] valid, logic last);
      lane_beat_type b;
      b.lane = lanes;
      b.lanes_valid = valid;
      b.last = last;
      pending_beats.push_back(b);
      beats_queued++;
   endtask

   initial begin
      logic [NumLanes-1:0][31:0] lanes;
      logic [31:0] thr_choice [8];
      logic [3:0] valid;
      thr_choice = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
                     32'hFFFF_FFFF, 32'h3F80_0000, 32'h7F7F_FFFF};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: zeros, infinities, NaN, lane counts at and beyond the edges.
      write_csr(CSR_COMPARE_MODE, CMP_GE);
      write_csr(CSR_THRESHOLD_BITS, 32'h0);
      queue_beat({32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
                  32'hFFFF_FFFF, 32'h3F80_0000, 32'h7FFF_FFFF}, 4'd8, 1'b0);
      queue_beat({8{32'hFFFF_FFFF}}, 4'd15, 1'b0);
      queue_beat({8{32'h0000_0001}}, 4'd0, 1'b0);
      queue_beat({8{32'h7F7F_FFFF}}, 4'd9, 1'b0);
      queue_beat({8{32'h8000_0000}}, 4'd1, 1'b1);
      queue_beat({8{32'h3F80_0000}}, 4'd0, 1'b1);
      queue_beat({8{32'h0000_0000}}, 4'd8, 1'b1);
      wait_drained();
      write_csr(CSR_COMPARE_MODE, CMP_EQ);
      write_csr(CSR_THRESHOLD_BITS, 32'h8000_0000);
      queue_beat({32'h0, 32'h8000_0000, 32'h1, 32'h8000_0001, 32'h0, 32'h7FC0_0000,
                  32'h8000_0000, 32'hFF80_0000}, 4'd8, 1'b1);
      queue_beat({8{32'h0}}, 4'd5, 1'b0);
      wait_drained();
      write_csr(CSR_THRESHOLD_BITS, 32'h7FC0_0001);
      queue_beat({8{32'h7FC0_0001}}, 4'd8, 1'b1);
      wait_drained();

      // Random phases walk every relation code, the undefined ones included.
      for (int phase = 0; phase < 16; phase++) begin
         write_csr(CSR_COMPARE_MODE, {$urandom_range(1) ? 29'($urandom) : 29'd0, 3'(phase % 8)});
         write_csr(CSR_THRESHOLD_BITS, phase >= 8 ? 32'($urandom) : thr_choice[phase]);
         steady <= phase == 3;
         hold_request <= phase == 5;
         for (int k = 0; k < 102; k++) begin
            for (int i = 0; i < NumLanes; i++) lanes[i] = pick_lane();
            case ($urandom_range(19))
               0: valid = 4'd0;
               1: valid = 4'($urandom_range(9, 15));
               default: valid = 4'($urandom_range(1, 8));
            endcase
            queue_beat(lanes, valid, $urandom_range(9) == 0);
         end
         if (phase == 5) repeat (20) @(posedge clock);
         hold_request <= 1'b0;
         wait_drained();
      end

      repeat (5) @(posedge clock);
      if (error_count == 0 && expected_kept.size() == 0) begin
         $display("threshold_stream_compaction regression: pass");
      end else begin
         $display("threshold_stream_compaction regression: fail");
      end
      $finish;
   end

endmodule
